// ----- rtl/stdag_pkg.sv -----
package stdag_pkg;

   localparam int DIM_BITS   = 16;
   localparam int INDEX_BITS = 40;
   localparam int ADDR_BITS  = 48;
   localparam int STRIDE_BITS = 32;
   localparam int CSR_IDX_BITS = 4;
   localparam int CSR_DATA_BITS = 48;
   localparam int VOL_BITS   = 3 * DIM_BITS;
   localparam int PLANE_BITS = 2 * DIM_BITS;
   localparam int SIDE_BITS  = INDEX_BITS + DIM_BITS;
   localparam int STEPS_A    = INDEX_BITS;
   localparam int STEPS_B    = DIM_BITS;
   localparam int STEPS_C    = DIM_BITS;
   localparam int NUM_CELLS  = STEPS_A + STEPS_B + STEPS_C;
   localparam int HALF_BITS  = INDEX_BITS / 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_BASE    = 4'd0,
      REG_SIZE0   = 4'd1,
      REG_SIZE1   = 4'd2,
      REG_SIZE2   = 4'd3,
      REG_STRIDE0 = 4'd4,
      REG_STRIDE1 = 4'd5,
      REG_STRIDE2 = 4'd6,
      REG_STRIDE3 = 4'd7
   } reg_idx_type;

   typedef struct packed {
      logic                  valid;
      logic [VOL_BITS-1:0]   rem;
      logic [INDEX_BITS-1:0] work;
      logic [SIDE_BITS-1:0]  side;
   } cell_type;

endpackage

// ----- rtl/stdag_req_if.sv -----
interface stdag_req_if import stdag_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] linear_index;
   modport source (output valid, output linear_index, input ready);
   modport sink (input valid, input linear_index, output ready);
endinterface

// ----- rtl/stdag_rsp_if.sv -----
interface stdag_rsp_if import stdag_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ADDR_BITS-1:0]  byte_address;
   logic [DIM_BITS-1:0]   coord0;
   logic [DIM_BITS-1:0]   coord1;
   logic [DIM_BITS-1:0]   coord2;
   logic [INDEX_BITS-1:0] coord3;
   modport source (output valid, output byte_address, output coord0, output coord1,
                   output coord2, output coord3, input ready);
   modport sink (input valid, input byte_address, input coord0, input coord1,
                 input coord2, input coord3, output ready);
endinterface

// ----- rtl/stdag_csr_if.sv -----
interface stdag_csr_if import stdag_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/stdag_div_cell.sv -----
module stdag_div_cell import stdag_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [VOL_BITS-1:0] divisor,
   input  cell_type            cell_in,
   output cell_type            cell_out
);

   cell_type          cell_ff;
   cell_type          cell_in_next;
   logic [VOL_BITS:0] shifted;
   logic [VOL_BITS:0] diff;
   logic              ge;

   always_comb begin
      shifted = {cell_in.rem, cell_in.work[INDEX_BITS-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      cell_in_next.valid = cell_in.valid;
      cell_in_next.rem   = ge ? diff[VOL_BITS-1:0] : shifted[VOL_BITS-1:0];
      cell_in_next.work  = {cell_in.work[INDEX_BITS-2:0], ge};
      cell_in_next.side  = cell_in.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff.valid <= cell_in_next.valid;
      end
      if (adv) begin
         cell_ff.rem  <= cell_in_next.rem;
         cell_ff.work <= cell_in_next.work;
         cell_ff.side <= cell_in_next.side;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- rtl/strided_tensor_address_gen.sv -----
// Channel  Port    Dir  Payload
// -------  ------  ---  -----------------------------------------------
// input    req_ch  in   linear_index[39:0]
// result   rsp_ch  out  byte_address[47:0], coord0..2[15:0], coord3[39:0]
// config   csr_ch  in   index[3:0], data[47:0]; always ready
//
// One item per cycle unless the output stalls or input is held off; 74 register
// stages: 72 restoring-division cells (one quotient bit each), one multiply stage,
// one sum and output register.
// Synchronous reset restores the register defaults and empties the pipe.
// A stalled output freezes the whole pipe unless the output register is empty.
// Input is held off after reset and after a register write.
module strided_tensor_address_gen import stdag_pkg::*; (
   input logic       clock,
   input logic       reset,
   stdag_req_if.sink   req_ch,
   stdag_rsp_if.source rsp_ch,
   stdag_csr_if.sink   csr_ch
);

   logic [ADDR_BITS-1:0]   base_ff;
   logic [DIM_BITS-1:0]    size0_ff, size1_ff, size2_ff;
   logic [STRIDE_BITS-1:0] stride0_ff, stride1_ff, stride2_ff, stride3_ff;
   logic [DIM_BITS-1:0]    d0_eff, d1_eff, d2_eff;
   logic [PLANE_BITS-1:0]  plane_ff;
   logic [VOL_BITS-1:0]    vol_ff;
   logic                   adv;
   logic [1:0]             hold_ff, hold_in;

   cell_type cell_in  [NUM_CELLS];
   cell_type cell_out [NUM_CELLS];
   logic [VOL_BITS-1:0] cell_div [NUM_CELLS];

   logic                  m_v_ff;
   logic [ADDR_BITS-1:0]  p0_ff, p1_ff, p2_ff, p3lo_ff;
   logic [HALF_BITS+STRIDE_BITS-1:0] p3hi_ff;
   logic [DIM_BITS-1:0]   mc0_ff, mc1_ff, mc2_ff;
   logic [INDEX_BITS-1:0] mc3_ff;

   logic                  out_v_ff;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [DIM_BITS-1:0]   oc0_ff, oc1_ff, oc2_ff;
   logic [INDEX_BITS-1:0] oc3_ff;

   cell_type last;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         size0_ff   <= DIM_BITS'(1);
         size1_ff   <= DIM_BITS'(1);
         size2_ff   <= DIM_BITS'(1);
         stride0_ff <= STRIDE_BITS'(4);
         stride1_ff <= STRIDE_BITS'(4);
         stride2_ff <= STRIDE_BITS'(4);
         stride3_ff <= STRIDE_BITS'(4);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_BASE:    base_ff    <= csr_ch.data[ADDR_BITS-1:0];
            REG_SIZE0:   size0_ff   <= csr_ch.data[DIM_BITS-1:0];
            REG_SIZE1:   size1_ff   <= csr_ch.data[DIM_BITS-1:0];
            REG_SIZE2:   size2_ff   <= csr_ch.data[DIM_BITS-1:0];
            REG_STRIDE0: stride0_ff <= csr_ch.data[STRIDE_BITS-1:0];
            REG_STRIDE1: stride1_ff <= csr_ch.data[STRIDE_BITS-1:0];
            REG_STRIDE2: stride2_ff <= csr_ch.data[STRIDE_BITS-1:0];
            REG_STRIDE3: stride3_ff <= csr_ch.data[STRIDE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign d0_eff = (size0_ff == '0) ? DIM_BITS'(1) : size0_ff;
   assign d1_eff = (size1_ff == '0) ? DIM_BITS'(1) : size1_ff;
   assign d2_eff = (size2_ff == '0) ? DIM_BITS'(1) : size2_ff;

   always_ff @(posedge clock) begin
      plane_ff <= PLANE_BITS'(d0_eff) * PLANE_BITS'(d1_eff);
      vol_ff   <= VOL_BITS'(plane_ff) * VOL_BITS'(d2_eff);
   end

   // hold input while the volume products settle
   always_comb begin
      if (csr_ch.valid) begin
         hold_in = 2'd2;
      end else if (hold_ff != 2'd0) begin
         hold_in = hold_ff - 2'd1;
      end else begin
         hold_in = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 2'd2;
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv && (hold_ff == 2'd0);

   genvar k;
   generate
      for (k = 0; k < NUM_CELLS; k++) begin : g_cell
         if (k == 0) begin : g_head
            always_comb begin
               cell_in[k].valid = req_ch.valid && req_ch.ready;
               cell_in[k].rem   = '0;
               cell_in[k].work  = req_ch.linear_index;
               cell_in[k].side  = '0;
            end
         end else if (k == STEPS_A || k == STEPS_A + STEPS_B) begin : g_seam
            // regroup: move the low remainder bits into the work word, the quotient into side
            always_comb begin
               cell_in[k].valid = cell_out[k-1].valid;
               cell_in[k].rem   = {{DIM_BITS{1'b0}}, cell_out[k-1].rem[VOL_BITS-1:DIM_BITS]};
               cell_in[k].work  = {cell_out[k-1].rem[DIM_BITS-1:0],
                                   {(INDEX_BITS-DIM_BITS){1'b0}}};
               if (k == STEPS_A) begin
                  cell_in[k].side = {{DIM_BITS{1'b0}}, cell_out[k-1].work};
               end else begin
                  cell_in[k].side = {cell_out[k-1].work[DIM_BITS-1:0],
                                     cell_out[k-1].side[INDEX_BITS-1:0]};
               end
            end
         end else begin : g_link
            assign cell_in[k] = cell_out[k-1];
         end

         if (k < STEPS_A) begin : g_dva
            assign cell_div[k] = vol_ff;
         end else if (k < STEPS_A + STEPS_B) begin : g_dvb
            assign cell_div[k] = VOL_BITS'(plane_ff);
         end else begin : g_dvc
            assign cell_div[k] = VOL_BITS'(d0_eff);
         end

         stdag_div_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .adv      (adv),
            .divisor  (cell_div[k]),
            .cell_in  (cell_in[k]),
            .cell_out (cell_out[k])
         );
      end
   endgenerate

   assign last = cell_out[NUM_CELLS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= last.valid;
      end
      if (adv) begin
         mc0_ff  <= last.rem[DIM_BITS-1:0];
         mc1_ff  <= last.work[DIM_BITS-1:0];
         mc2_ff  <= last.side[SIDE_BITS-1:INDEX_BITS];
         mc3_ff  <= last.side[INDEX_BITS-1:0];
         p0_ff   <= ADDR_BITS'(last.rem[DIM_BITS-1:0]) * ADDR_BITS'(stride0_ff);
         p1_ff   <= ADDR_BITS'(last.work[DIM_BITS-1:0]) * ADDR_BITS'(stride1_ff);
         p2_ff   <= ADDR_BITS'(last.side[SIDE_BITS-1:INDEX_BITS]) * ADDR_BITS'(stride2_ff);
         p3lo_ff <= ADDR_BITS'(last.side[HALF_BITS-1:0]) * ADDR_BITS'(stride3_ff);
         p3hi_ff <= (HALF_BITS+STRIDE_BITS)'(last.side[INDEX_BITS-1:HALF_BITS])
                    * (HALF_BITS+STRIDE_BITS)'(stride3_ff);
      end
   end

   assign addr_in = base_ff + p0_ff + p1_ff + p2_ff + p3lo_ff
                  + {p3hi_ff[ADDR_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= m_v_ff;
      end
      if (adv) begin
         addr_ff <= addr_in;
         oc0_ff  <= mc0_ff;
         oc1_ff  <= mc1_ff;
         oc2_ff  <= mc2_ff;
         oc3_ff  <= mc3_ff;
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.byte_address = addr_ff;
   assign rsp_ch.coord0       = oc0_ff;
   assign rsp_ch.coord1       = oc1_ff;
   assign rsp_ch.coord2       = oc2_ff;
   assign rsp_ch.coord3       = oc3_ff;

   a_coord0_bound: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> oc0_ff < d0_eff) else $error("coord0 out of range");
   a_coord1_bound: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> oc1_ff < d1_eff) else $error("coord1 out of range");
   a_coord2_bound: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> oc2_ff < d2_eff) else $error("coord2 out of range");
   a_mult_moves: assert property (@(posedge clock) disable iff (reset)
      (m_v_ff && adv) |=> out_v_ff) else $error("item lost between stages");

endmodule

// ----- test/strided_tensor_address_gen_tb.sv -----
module strided_tensor_address_gen_tb import stdag_pkg::*; ();

   typedef struct packed {
      logic [ADDR_BITS-1:0]  byte_address;
      logic [DIM_BITS-1:0]   coord0;
      logic [DIM_BITS-1:0]   coord1;
      logic [DIM_BITS-1:0]   coord2;
      logic [INDEX_BITS-1:0] coord3;
   } location_type;

   logic clock;
   logic reset;
   int   cycle;
   int   errors;
   int   issued;
   int   checked;
   int   phases;

   logic [ADDR_BITS-1:0]   base_q;
   logic [DIM_BITS-1:0]    size_q [3];
   logic [STRIDE_BITS-1:0] stride_q [4];

   logic [INDEX_BITS-1:0] index_queue [$];
   location_type          location_queue [$];

   stdag_req_if req_ch ();
   stdag_rsp_if rsp_ch ();
   stdag_csr_if csr_ch ();

   strided_tensor_address_gen dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void add_index(input logic [INDEX_BITS-1:0] x);
      index_queue.insert(index_queue.size(), x);
   endfunction

   function automatic void add_location(input location_type x);
      location_queue.insert(location_queue.size(), x);
   endfunction

   function automatic location_type unravel(input logic [INDEX_BITS-1:0] idx);
      logic [63:0] d0, d1, d2, plane, vol, rest, c0, c1, c2, c3, sum;
      location_type r;
      d0 = (size_q[0] == 0) ? 64'd1 : 64'(size_q[0]);
      d1 = (size_q[1] == 0) ? 64'd1 : 64'(size_q[1]);
      d2 = (size_q[2] == 0) ? 64'd1 : 64'(size_q[2]);
      plane = d0 * d1;
      vol = plane * d2;
      c3 = 64'(idx) / vol;
      rest = 64'(idx) % vol;
      c2 = rest / plane;
      rest = rest % plane;
      c1 = rest / d0;
      c0 = rest % d0;
      sum = 64'(base_q) + c0 * 64'(stride_q[0]) + c1 * 64'(stride_q[1])
            + c2 * 64'(stride_q[2]) + c3 * 64'(stride_q[3]);
      r.byte_address = sum[ADDR_BITS-1:0];
      r.coord0 = c0[DIM_BITS-1:0];
      r.coord1 = c1[DIM_BITS-1:0];
      r.coord2 = c2[DIM_BITS-1:0];
      r.coord3 = c3[INDEX_BITS-1:0];
      return r;
   endfunction

   function automatic bit idle_now();
      return ((cycle % 5000) >= 1200) && ($urandom_range(99) < 22);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.linear_index <= '0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !idle_now();
         if (!req_ch.valid || req_ch.ready) begin
            if (index_queue.size() != 0 && !idle_now()) begin
               req_ch.valid <= 1'b1;
               req_ch.linear_index <= index_queue.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      location_type want;
      if (reset) begin
         base_q <= '0;
         size_q <= '{default: 1};
         stride_q <= '{default: 4};
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (reg_idx_type'(csr_ch.index))
               REG_BASE:    base_q <= csr_ch.data[ADDR_BITS-1:0];
               REG_SIZE0:   size_q[0] <= csr_ch.data[DIM_BITS-1:0];
               REG_SIZE1:   size_q[1] <= csr_ch.data[DIM_BITS-1:0];
               REG_SIZE2:   size_q[2] <= csr_ch.data[DIM_BITS-1:0];
               REG_STRIDE0: stride_q[0] <= csr_ch.data[STRIDE_BITS-1:0];
               REG_STRIDE1: stride_q[1] <= csr_ch.data[STRIDE_BITS-1:0];
               REG_STRIDE2: stride_q[2] <= csr_ch.data[STRIDE_BITS-1:0];
               REG_STRIDE3: stride_q[3] <= csr_ch.data[STRIDE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            add_location(unravel(req_ch.linear_index));
            issued++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (location_queue.size() == 0) begin
               $error("unexpected item: address %h", rsp_ch.byte_address);
               errors++;
            end else begin
               want = location_queue.pop_front();
               checked++;
               if (rsp_ch.byte_address !== want.byte_address) begin
                  $error("byte_address: expected %h, got %h", want.byte_address,
                         rsp_ch.byte_address);
                  errors++;
               end
               if (rsp_ch.coord0 !== want.coord0) begin
                  $error("coord0: expected %h, got %h", want.coord0, rsp_ch.coord0);
                  errors++;
               end
               if (rsp_ch.coord1 !== want.coord1) begin
                  $error("coord1: expected %h, got %h", want.coord1, rsp_ch.coord1);
                  errors++;
               end
               if (rsp_ch.coord2 !== want.coord2) begin
                  $error("coord2: expected %h, got %h", want.coord2, rsp_ch.coord2);
                  errors++;
               end
               if (rsp_ch.coord3 !== want.coord3) begin
                  $error("coord3: expected %h, got %h", want.coord3, rsp_ch.coord3);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 300000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      while (index_queue.size() != 0 || req_ch.valid || location_queue.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(input logic [ADDR_BITS-1:0] base,
                            input logic [DIM_BITS-1:0] s0, s1, s2,
                            input logic [STRIDE_BITS-1:0] t0, t1, t2, t3);
      drain();
      write_reg(REG_BASE, base);
      write_reg(REG_SIZE0, CSR_DATA_BITS'(s0));
      write_reg(REG_SIZE1, CSR_DATA_BITS'(s1));
      write_reg(REG_SIZE2, CSR_DATA_BITS'(s2));
      write_reg(REG_STRIDE0, CSR_DATA_BITS'(t0));
      write_reg(REG_STRIDE1, CSR_DATA_BITS'(t1));
      write_reg(REG_STRIDE2, CSR_DATA_BITS'(t2));
      write_reg(REG_STRIDE3, CSR_DATA_BITS'(t3));
      // unknown register, must be ignored
      write_reg(CSR_IDX_BITS'($urandom_range(15, 8)), CSR_DATA_BITS'({$urandom, $urandom}));
      csr_ch.valid <= 1'b0;
      repeat (4) @(posedge clock);
      phases++;
   endtask

   task automatic push_random(input int count);
      logic [63:0] vol;
      logic [63:0] v;
      vol = 64'((size_q[0] == 0) ? 1 : size_q[0]) * 64'((size_q[1] == 0) ? 1 : size_q[1])
            * 64'((size_q[2] == 0) ? 1 : size_q[2]);
      for (int i = 0; i < count; i++) begin
         v = {$urandom, $urandom};
         case ($urandom_range(3))
            0: add_index(v[INDEX_BITS-1:0]);
            1: add_index(INDEX_BITS'(v % (vol * 4)));
            2: add_index(INDEX_BITS'(vol * $urandom_range(3) + $urandom_range(2)));
            default: add_index(INDEX_BITS'(v % vol));
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      cycle = 0;
      errors = 0;
      issued = 0;
      checked = 0;
      phases = 0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_index('0);
      add_index('1);
      add_index(INDEX_BITS'(1));
      push_random(40);

      configure('1, 16'hffff, 16'hffff, 16'hffff, '1, '1, '1, '1);
      add_index('0);
      add_index('1);
      add_index(INDEX_BITS'(16'hffff));
      add_index(INDEX_BITS'(32'hfffe_0001));
      add_index(INDEX_BITS'(48'hfffd_0002_ffff));
      push_random(150);

      configure(48'h1000, 16'd0, 16'd0, 16'd0, 32'd8, 32'd16, 32'd32, 32'd64);
      add_index('0);
      add_index('1);
      push_random(150);

      configure(48'hffff_ffff_ff00, 16'd3, 16'd0, 16'd5, 32'd4, 32'd12, 32'd0, 32'd60);
      push_random(200);

      configure('0, 16'd1, 16'd1, 16'd1, '0, '0, '0, '0);
      push_random(100);

      repeat (6) begin
         configure(ADDR_BITS'({$urandom, $urandom}), DIM_BITS'($urandom_range(1, 9)),
                   DIM_BITS'($urandom_range(0, 300)), DIM_BITS'($urandom),
                   $urandom, $urandom, STRIDE_BITS'($urandom_range(0, 1024)), $urandom);
         push_random(200);
      end

      drain();
      $display("Checked %0d of %0d items over %0d register settings.", checked, issued,
               phases + 1);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- strided_tensor_address_gen.f -----
rtl/stdag_pkg.sv
rtl/stdag_req_if.sv
rtl/stdag_rsp_if.sv
rtl/stdag_csr_if.sv
rtl/stdag_div_cell.sv
rtl/strided_tensor_address_gen.sv
test/strided_tensor_address_gen_tb.sv
